>>> hw/rtl/bped_pkg.sv
package bped_pkg;

   localparam int PATTERN_MAX_DEF  = 64;
   localparam int SYMBOL_WIDTH_DEF = 8;

   localparam int CMD_WIDTH   = 2;
   localparam int POS_WIDTH   = 6;
   localparam int LEN_WIDTH   = 7;
   localparam int DIST_WIDTH  = 32;
   localparam int DELTA_WIDTH = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_START = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_STEP  = 2'd2;

   localparam logic [LEN_WIDTH-1:0]  LEN_RESET = 7'd64;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX  = 32'hFFFF_FFFF;

   localparam logic signed [DELTA_WIDTH-1:0] DELTA_ZERO = 2'sb00;
   localparam logic signed [DELTA_WIDTH-1:0] DELTA_UP   = 2'sb01;
   localparam logic signed [DELTA_WIDTH-1:0] DELTA_DOWN = 2'sb11;

   // one-hot command strobes, already qualified by the pipeline advancing
   typedef struct packed {
      logic load;
      logic start;
      logic step;
   } ctrl_type;

endpackage

>>> hw/rtl/bped_if.sv
interface bped_req_if import bped_pkg::*; #(parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF);
   logic                    valid;
   logic                    ready;
   logic [CMD_WIDTH-1:0]    cmd;
   logic [POS_WIDTH-1:0]    position;
   logic [SYMBOL_WIDTH-1:0] symbol;

   modport source (output valid, cmd, position, symbol, input ready);
   modport sink (input valid, cmd, position, symbol, output ready);
endinterface

interface bped_rsp_if import bped_pkg::*;;
   logic                           valid;
   logic                           ready;
   logic [DIST_WIDTH-1:0]          distance;
   logic signed [DELTA_WIDTH-1:0]  delta;

   modport source (output valid, distance, delta, input ready);
   modport sink (input valid, distance, delta, output ready);
endinterface

>>> hw/rtl/bped_pattern_store.sv
module bped_pattern_store import bped_pkg::*; #(
   parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
   parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
) (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic [POS_WIDTH-1:0]    position,
   input  logic [SYMBOL_WIDTH-1:0] symbol,
   output logic [PATTERN_MAX-1:0]  match
);

   logic [SYMBOL_WIDTH-1:0] pattern_ff [PATTERN_MAX];

   // a position at or above the pattern size matches no entry and is dropped
   always_ff @(posedge clock) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (ctrl.load && position == POS_WIDTH'(i)) begin
            pattern_ff[i] <= symbol;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         match[i] = (pattern_ff[i] == symbol);
      end
   end

endmodule

>>> hw/rtl/bped_step_core.sv
module bped_step_core import bped_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_type                      ctrl,
   input  logic [PATTERN_MAX-1:0]        match,
   input  logic [LEN_WIDTH-1:0]          length,
   output logic [DIST_WIDTH-1:0]         distance,
   output logic signed [DELTA_WIDTH-1:0] delta
);

   localparam logic [LEN_WIDTH-1:0] MaxLen = LEN_WIDTH'(PATTERN_MAX);

   logic [PATTERN_MAX-1:0] vp_ff, vp_in;
   logic [PATTERN_MAX-1:0] vn_ff, vn_in;
   logic [DIST_WIDTH-1:0]  dist_ff, dist_in;

   logic [LEN_WIDTH-1:0]   eff_len;
   logic [PATTERN_MAX-1:0] mask, top;
   logic [PATTERN_MAX-1:0] vp, vn, xv, xh, hp, hn, hp_sh, hn_sh, sum;
   logic                   up, down;

   always_comb begin
      if (length == '0) begin
         eff_len = LEN_WIDTH'(1);
      end else if (length > MaxLen) begin
         eff_len = MaxLen;
      end else begin
         eff_len = length;
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
         mask[i] = (LEN_WIDTH'(i) < eff_len);
         top[i]  = (LEN_WIDTH'(i) == eff_len - 1'b1);
      end
   end

   // myers column update
   always_comb begin
      vp    = vp_ff & mask;
      vn    = vn_ff & mask;
      xv    = (match | vn) & mask;
      sum   = (match & vp) + vp;
      xh    = ((sum ^ vp) | match | vn) & mask;
      hp    = (vn | ~(xh | vp)) & mask;
      hn    = vp & xh & mask;
      up    = |(hp & top);
      down  = |(hn & top);
      hp_sh = {hp[PATTERN_MAX-2:0], 1'b1} & mask;
      hn_sh = {hn[PATTERN_MAX-2:0], 1'b0} & mask;
   end

   always_comb begin
      vp_in   = vp_ff;
      vn_in   = vn_ff;
      dist_in = dist_ff;
      delta   = DELTA_ZERO;
      if (ctrl.start) begin
         vp_in   = mask;
         vn_in   = '0;
         dist_in = DIST_WIDTH'(eff_len);
      end else if (ctrl.step) begin
         vp_in = (hn_sh | ~(hp_sh | xv)) & mask;
         vn_in = hp_sh & xv & mask;
         // saturate at both ends, reporting no change there
         if (up) begin
            if (dist_ff != DIST_MAX) begin
               dist_in = dist_ff + 1'b1;
               delta   = DELTA_UP;
            end
         end else if (down) begin
            if (dist_ff != '0) begin
               dist_in = dist_ff - 1'b1;
               delta   = DELTA_DOWN;
            end
         end
      end
   end

   assign distance = dist_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff   <= '1;
         vn_ff   <= '0;
         dist_ff <= '0;
      end else begin
         vp_ff   <= vp_in;
         vn_ff   <= vn_in;
         dist_ff <= dist_in;
      end
   end

   a_vectors_disjoint: assert property (@(posedge clock) disable iff (reset)
      (vp_ff & vn_ff) == '0)
      else $error("positive and negative vectors overlap");

   a_up_increments: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && delta == DELTA_UP) |=> dist_ff == $past(dist_ff) + 1'b1)
      else $error("upward delta without increment");

   a_start_distance: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> (dist_ff != '0 && dist_ff <= DIST_WIDTH'(PATTERN_MAX)))
      else $error("start distance out of range");

endmodule

>>> hw/rtl/bit_parallel_edit_distance_unit.sv
// Streaming edit distance against a stored pattern (Myers bit-vector scheme).
// Requests arrive on req_bus (valid/ready) with a command: load writes one
// pattern symbol at a position, start opens a new comparison with the
// distance set to the pattern length, step compares one text symbol against
// every pattern symbol at once and updates the distance. Every request gives
// exactly one response on rsp_bus with the distance after it and the change
// (-1, 0, +1) made by a step.
// csr_wr_en/csr_wr_data set the pattern length; write it only while idle.
// A request passes through the request register, then the column update
// and the response register. Throughput is one request per cycle while
// the response register is free or rsp_bus is ready; the whole update is
// a single pattern-wide add plus bitwise logic between those registers.
// When rsp_bus stalls, the response register holds, the request register
// fills, and req_bus.ready drops until the response is taken.
// Reset clears the vectors (positive all ones), the distance to zero and the
// length to 64; pattern symbols are not cleared and must be loaded first.
module bit_parallel_edit_distance_unit import bped_pkg::*; #(
   parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
   parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [LEN_WIDTH-1:0] csr_wr_data,
   bped_req_if.sink             req_bus,
   bped_rsp_if.source           rsp_bus
);

   logic [LEN_WIDTH-1:0]          len_ff;
   logic                          req_valid_ff;
   logic [CMD_WIDTH-1:0]          cmd_ff;
   logic [POS_WIDTH-1:0]          pos_ff;
   logic [SYMBOL_WIDTH-1:0]       sym_ff;
   logic                          rsp_valid_ff;
   logic [DIST_WIDTH-1:0]         dist_ff;
   logic signed [DELTA_WIDTH-1:0] delta_ff;

   logic                          advance;
   ctrl_type                      ctrl;
   logic [PATTERN_MAX-1:0]        match;
   logic [DIST_WIDTH-1:0]         dist_in;
   logic signed [DELTA_WIDTH-1:0] delta_in;

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;

   always_comb begin
      ctrl = '0;
      if (advance) begin
         case (cmd_ff)
            CMD_LOAD:  ctrl.load  = 1'b1;
            CMD_START: ctrl.start = 1'b1;
            CMD_STEP:  ctrl.step  = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         if (req_bus.ready) begin
            req_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         cmd_ff <= req_bus.cmd;
         pos_ff <= req_bus.position;
         sym_ff <= req_bus.symbol;
      end
      if (advance) begin
         dist_ff  <= dist_in;
         delta_ff <= delta_in;
      end
   end

   bped_pattern_store #(
      .PATTERN_MAX  (PATTERN_MAX),
      .SYMBOL_WIDTH (SYMBOL_WIDTH)
   ) u_store (
      .clock    (clock),
      .ctrl     (ctrl),
      .position (pos_ff),
      .symbol   (sym_ff),
      .match    (match)
   );

   bped_step_core #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .match    (match),
      .length   (len_ff),
      .distance (dist_in),
      .delta    (delta_in)
   );

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.distance = dist_ff;
   assign rsp_bus.delta    = delta_ff;

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request left no response");

   a_rsp_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("response appeared without a request");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while pipeline full");

endmodule

>>> tb/sv/tb_bit_parallel_edit_distance_unit.sv
module tb_bit_parallel_edit_distance_unit;
   import bped_pkg::*;

   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
   localparam int WAIT_MAX = 17;
   localparam int DIRECTED_ROWS = 21;
   localparam int RANDOM_ITEMS = 1000;

   typedef struct {
      logic [DIST_WIDTH-1:0]         distance;
      logic signed [DELTA_WIDTH-1:0] delta;
   } dist_rsp_type;

   typedef struct {
      bit                            set_len;
      logic [LEN_WIDTH-1:0]          len;
      logic [CMD_WIDTH-1:0]          cmd;
      logic [POS_WIDTH-1:0]          pos;
      logic [SYMBOL_WIDTH_DEF-1:0]   sym;
      bit                            known;
      logic [DIST_WIDTH-1:0]         exp_dist;
      logic signed [DELTA_WIDTH-1:0] dlt;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [LEN_WIDTH-1:0] csr_wr_data;

   bped_req_if #(.SYMBOL_WIDTH(SYMBOL_WIDTH_DEF)) req_bus ();
   bped_rsp_if rsp_bus ();

   bit_parallel_edit_distance_unit #(
      .PATTERN_MAX  (PATTERN_MAX_DEF),
      .SYMBOL_WIDTH (SYMBOL_WIDTH_DEF)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always #6 clock = ~clock;

   // shadow of the block state
   logic [SYMBOL_WIDTH_DEF-1:0] pattern_mem [PATTERN_MAX_DEF];
   logic [PATTERN_MAX_DEF-1:0]  loaded = '0;
   logic [63:0]                 pos_vec = {64{1'b1}};
   logic [63:0]                 neg_vec = '0;
   logic [DIST_WIDTH-1:0]       dist_now = '0;
   logic [LEN_WIDTH-1:0]        length_reg = LEN_RESET;

   dist_rsp_type expected_distances [$];
   dist_rsp_type oldest;
   stim_row_type directed_rows [DIRECTED_ROWS];

   int  mismatches = 0;
   int  requests_sent = 0;
   int  steps_sent = 0;
   int  length_writes = 0;
   int  rises = 0;
   int  drops = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, WAIT_MAX);
   endfunction

   function automatic int eff_length();
      if (length_reg == 0) return 1;
      if (length_reg > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
      return int'(length_reg);
   endfunction

   function automatic dist_rsp_type distance_after(input logic [CMD_WIDTH-1:0] cmd,
                                                   input logic [POS_WIDTH-1:0] pos,
                                                   input logic [SYMBOL_WIDTH_DEF-1:0] sym);
      int n;
      int d;
      logic [63:0] mm, top, eq, vp, vn, xv, xh, hp, hn;
      dist_rsp_type r;
      n = eff_length();
      mm = (n == 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
      top = 64'd1 << (n - 1);
      d = 0;
      eq = '0;
      case (cmd)
         CMD_LOAD: begin
            pattern_mem[pos] = sym;
            loaded[pos] = 1'b1;
         end
         CMD_START: begin
            pos_vec = mm;
            neg_vec = '0;
            dist_now = DIST_WIDTH'(n);
         end
         CMD_STEP: begin
            for (int i = 0; i < n; i++)
               if (pattern_mem[i] == sym) eq[i] = 1'b1;
            vp = pos_vec & mm;
            vn = neg_vec & mm;
            xv = (eq | vn) & mm;
            xh = ((((eq & vp) + vp) ^ vp) | eq | vn) & mm;
            hp = (vn | ~(xh | vp)) & mm;
            hn = (vp & xh) & mm;
            if ((hp & top) != 0) d = 1;
            else if ((hn & top) != 0) d = -1;
            hp = ((hp << 1) | 64'd1) & mm;
            hn = (hn << 1) & mm;
            pos_vec = (hn | ~(hp | xv)) & mm;
            neg_vec = (hp & xv) & mm;
            // distance saturates at both ends and then reports no change
            if (d > 0) begin
               if (dist_now == DIST_MAX) d = 0;
               else dist_now++;
            end else if (d < 0) begin
               if (dist_now == 0) d = 0;
               else dist_now--;
            end
         end
         default: ;
      endcase
      r.distance = dist_now;
      r.delta = (d > 0) ? DELTA_UP : ((d < 0) ? DELTA_DOWN : DELTA_ZERO);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   // caller sits on a clock edge where nothing else drives valid
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_distances.size() != 0);
   endtask

   task automatic write_length(input logic [LEN_WIDTH-1:0] len);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      length_reg = len;
      length_writes++;
   endtask

   task automatic issue_request(input logic [CMD_WIDTH-1:0] cmd,
                                input logic [POS_WIDTH-1:0] pos,
                                input logic [SYMBOL_WIDTH_DEF-1:0] sym,
                                input bit known,
                                input logic [DIST_WIDTH-1:0] known_dist,
                                input logic signed [DELTA_WIDTH-1:0] known_dlt);
      int gap;
      dist_rsp_type predicted;
      gap = draw_wait();
      predicted = distance_after(cmd, pos, sym);
      if (known) begin
         predicted.distance = known_dist;
         predicted.delta = known_dlt;
      end
      expected_distances.push_back(predicted);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cmd      <= cmd;
      req_bus.position <= pos;
      req_bus.symbol   <= sym;
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
      if (cmd == CMD_STEP) steps_sent++;
   endtask

   // response side: check in order, then draw the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_distances.size() == 0) begin
               note_mismatch("response with no request pending", rsp_bus.distance, 0);
            end else begin
               oldest = expected_distances.pop_front();
               if (rsp_bus.distance !== oldest.distance)
                  note_mismatch("distance", rsp_bus.distance, oldest.distance);
               if (rsp_bus.delta !== oldest.delta)
                  note_mismatch("delta", longint'(rsp_bus.delta), longint'(oldest.delta));
               if (rsp_bus.delta === DELTA_UP) rises++;
               if (rsp_bus.delta === DELTA_DOWN) drops++;
            end
            stall_left = draw_wait();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int phase;
      int new_len;
      int span;
      int steps;
      int pick;
      logic [SYMBOL_WIDTH_DEF-1:0] alphabet [4];

      req_bus.valid    <= 1'b0;
      req_bus.cmd      <= CMD_LOAD;
      req_bus.position <= '0;
      req_bus.symbol   <= '0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;

      directed_rows = '{
         // reset state, unknown command
         '{1'b0, 7'd0,   CMD_UNUSED, 6'd0,  8'h00, 1'b1, 32'd0,  DELTA_ZERO},
         '{1'b1, 7'd1,   CMD_LOAD,   6'd0,  8'hFF, 1'b1, 32'd0,  DELTA_ZERO},
         // step before start, match at distance zero stays at zero
         '{1'b0, 7'd0,   CMD_STEP,   6'd0,  8'hFF, 1'b1, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_STEP,   6'd0,  8'h00, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_START,  6'd0,  8'h00, 1'b1, 32'd1,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_STEP,   6'd63, 8'h00, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_STEP,   6'd0,  8'hFF, 1'b0, 32'd0,  DELTA_ZERO},
         // length zero acts as one
         '{1'b1, 7'd0,   CMD_START,  6'd0,  8'h00, 1'b1, 32'd1,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_STEP,   6'd0,  8'hFF, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b1, 7'd2,   CMD_LOAD,   6'd1,  8'h00, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_START,  6'd0,  8'h00, 1'b1, 32'd2,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_STEP,   6'd0,  8'h00, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_STEP,   6'd0,  8'hFF, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_STEP,   6'd0,  8'hAA, 1'b0, 32'd0,  DELTA_ZERO},
         // length changed in the middle of a comparison
         '{1'b1, 7'd1,   CMD_STEP,   6'd0,  8'h55, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b1, 7'd2,   CMD_STEP,   6'd0,  8'hFF, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_LOAD,   6'd63, 8'h00, 1'b0, 32'd0,  DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_UNUSED, 6'd63, 8'hFF, 1'b0, 32'd0,  DELTA_ZERO},
         // length above the maximum clamps to 64
         '{1'b1, 7'd127, CMD_START,  6'd0,  8'h00, 1'b1, 32'd64, DELTA_ZERO},
         '{1'b0, 7'd0,   CMD_UNUSED, 6'd0,  8'h00, 1'b1, 32'd64, DELTA_ZERO},
         '{1'b1, 7'd64,  CMD_START,  6'd63, 8'hFF, 1'b1, 32'd64, DELTA_ZERO}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_len) write_length(directed_rows[r].len);
         issue_request(directed_rows[r].cmd, directed_rows[r].pos, directed_rows[r].sym,
                       directed_rows[r].known, directed_rows[r].exp_dist,
                       directed_rows[r].dlt);
      end

      phase = 0;
      while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       new_len = 1;
            1:       new_len = 64;
            2:       new_len = 0;
            3:       new_len = 127;
            4:       new_len = $urandom_range(65, 127);
            5, 6:    new_len = $urandom_range(17, 64);
            default: new_len = $urandom_range(2, 16);
         endcase
         write_length(new_len[LEN_WIDTH-1:0]);
         calm = ($urandom_range(0, 3) == 0);
         foreach (alphabet[a]) alphabet[a] = SYMBOL_WIDTH_DEF'($urandom_range(0, 255));

         // every entry under the length is loaded before any step reads it
         span = eff_length();
         for (int i = 0; i < span; i++)
            if (!loaded[i] || $urandom_range(0, 2) == 0)
               issue_request(CMD_LOAD, POS_WIDTH'(i), alphabet[$urandom_range(0, 3)],
                             1'b0, '0, DELTA_ZERO);
         issue_request(CMD_START, POS_WIDTH'($urandom_range(0, 63)),
                       SYMBOL_WIDTH_DEF'($urandom_range(0, 255)), 1'b0, '0, DELTA_ZERO);

         steps = $urandom_range(10, 80);
         for (int k = 0; k < steps; k++) begin
            if (k == steps / 2 && (phase == 1 || $urandom_range(0, 7) == 0))
               drain_responses();
            pick = $urandom_range(0, 19);
            case (pick)
               0: issue_request(CMD_UNUSED, POS_WIDTH'($urandom_range(0, 63)),
                                SYMBOL_WIDTH_DEF'($urandom_range(0, 255)),
                                1'b0, '0, DELTA_ZERO);
               1: issue_request(CMD_LOAD, POS_WIDTH'($urandom_range(0, 63)),
                                SYMBOL_WIDTH_DEF'($urandom_range(0, 255)),
                                1'b0, '0, DELTA_ZERO);
               2: issue_request(CMD_START, POS_WIDTH'($urandom_range(0, 63)),
                                SYMBOL_WIDTH_DEF'($urandom_range(0, 255)),
                                1'b0, '0, DELTA_ZERO);
               3: issue_request(CMD_STEP, POS_WIDTH'($urandom_range(0, 63)),
                                SYMBOL_WIDTH_DEF'($urandom_range(0, 255)),
                                1'b0, '0, DELTA_ZERO);
               default: issue_request(CMD_STEP, POS_WIDTH'($urandom_range(0, 63)),
                                      alphabet[$urandom_range(0, 3)], 1'b0, '0, DELTA_ZERO);
            endcase
         end
         phase++;
      end

      calm = 1'b0;
      drain_responses();
      repeat (4) @(posedge clock);
      if (expected_distances.size() != 0)
         note_mismatch("requests without response", expected_distances.size(), 0);

      $display("covered %0d requests in %0d length settings, %0d text steps",
               requests_sent, length_writes, steps_sent);
      $display("distance rose %0d times and fell %0d times, %0d mismatches",
               rises, drops, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
